[sv/stc_pkg.sv]
package stc_pkg;

	localparam int MAX_MEMBERS_DEF = 32;
	localparam int STRIP_BITS_DEF  = 10;
	localparam int TIME_BITS_DEF   = 16;
	localparam int ID_BITS         = 16;
	localparam int CFG_IDX_BITS    = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE     = 2'd2;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_OFFER = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// probe word moving down the cell row
	typedef struct packed {
		logic vld;
		logic match;
	} tok_ctl_t;

	// member store write control, broadcast to all cells
	typedef struct packed {
		logic clear;
		logic en;
	} wr_ctl_t;

endpackage

[sv/stc_hit_if.sv]
interface stc_hit_if #(
	parameter int STRIP_BITS = stc_pkg::STRIP_BITS_DEF,
	parameter int TIME_BITS  = stc_pkg::TIME_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [stc_pkg::ID_BITS-1:0] hit_id;
	logic [STRIP_BITS-1:0]       strip;
	logic [TIME_BITS-1:0]        time_first;
	logic [TIME_BITS-1:0]        time_second;

	modport source (
		output valid, command, hit_id, strip, time_first, time_second,
		input  ready
	);
	modport sink (
		input  valid, command, hit_id, strip, time_first, time_second,
		output ready
	);
endinterface

[sv/stc_res_if.sv]
interface stc_res_if #(
	parameter int CNT_W     = 6,
	parameter int TIME_BITS = stc_pkg::TIME_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic                        full_reject;
	logic [CNT_W-1:0]            member_count;
	logic [stc_pkg::ID_BITS-1:0] center_id;
	logic [TIME_BITS-1:0]        center_time;

	modport source (
		output valid, accepted, full_reject, member_count, center_id, center_time,
		input  ready
	);
	modport sink (
		input  valid, accepted, full_reject, member_count, center_id, center_time,
		output ready
	);
endinterface

[sv/stc_cell.sv]
module stc_cell #(
	parameter int STRIP_BITS = stc_pkg::STRIP_BITS_DEF,
	parameter int TIME_BITS  = stc_pkg::TIME_BITS_DEF,
	parameter int IDX_W      = 5,
	parameter int CELL_IDX   = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [STRIP_BITS-1:0] max_dist,
	input  logic [TIME_BITS-1:0]  window,
	input  stc_pkg::tok_ctl_t     tok_in,
	input  logic [STRIP_BITS-1:0] tok_strip_in,
	input  logic [TIME_BITS-1:0]  tok_time_in,
	output stc_pkg::tok_ctl_t     tok_out,
	output logic [STRIP_BITS-1:0] tok_strip_out,
	output logic [TIME_BITS-1:0]  tok_time_out,
	input  stc_pkg::wr_ctl_t      wr,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [STRIP_BITS-1:0] wr_strip,
	input  logic [TIME_BITS-1:0]  wr_time
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                  valid_q;
	logic [STRIP_BITS-1:0] strip_q;
	logic [TIME_BITS-1:0]  time_q;
	logic                  tok_vld_q;
	logic                  tok_match_q;
	logic [STRIP_BITS-1:0] tok_strip_q;
	logic [TIME_BITS-1:0]  tok_time_q;

	logic [STRIP_BITS-1:0] d_strip;
	logic [TIME_BITS-1:0]  d_time;
	logic                  hit;
	logic                  wr_me;

	always_comb begin
		d_strip = (tok_strip_in >= strip_q) ? (tok_strip_in - strip_q)
			: (strip_q - tok_strip_in);
		d_time  = (tok_time_in >= time_q) ? (tok_time_in - time_q)
			: (time_q - tok_time_in);
		hit     = tok_in.vld && valid_q && (d_strip <= max_dist) && (d_time < window);
	end

	assign wr_me = wr.en && (wr_idx == MY_IDX);

	// member store: valid bit resets, payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_me) begin
			valid_q <= 1'b1;
		end else if (wr.clear) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me) begin
			strip_q <= wr_strip;
			time_q  <= wr_time;
		end
	end

	// probe hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_match_q <= tok_in.match || hit;
		tok_strip_q <= tok_strip_in;
		tok_time_q  <= tok_time_in;
	end

	assign tok_out.vld   = tok_vld_q;
	assign tok_out.match = tok_match_q;
	assign tok_strip_out = tok_strip_q;
	assign tok_time_out  = tok_time_q;

endmodule

[sv/strip_time_hit_clusterer_unit.sv]
// Channel   Dir  Word
// hit       in   command, hit_id, strip, time_first, time_second
// result    out  accepted, full_reject, member_count, center_id, center_time
// cfg_*     in   write-only register port: strip reach, time window, side select
//
// A start word goes from accept straight to commit; an offer word first sends
// its probe along the row of MAX_MEMBERS member cells, one cell per cycle,
// and then commits. One word is in work at a time.
// The result sits in an output register, so a new hit is taken while the last
// result still waits; commit stalls only if that register is still occupied.
// Reset clears member valid bits, count, center and registers to defaults.
module strip_time_hit_clusterer_unit #(
	parameter  int MAX_MEMBERS = stc_pkg::MAX_MEMBERS_DEF,
	parameter  int STRIP_BITS  = stc_pkg::STRIP_BITS_DEF,
	parameter  int TIME_BITS   = stc_pkg::TIME_BITS_DEF,
	localparam int CFG_W       = (STRIP_BITS > TIME_BITS) ? STRIP_BITS : TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	stc_hit_if.sink                          hit,
	stc_res_if.source                        result,
	input  logic                             cfg_wen,
	input  logic [stc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_W-1:0]                 cfg_data
);

	localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
	localparam int IDX_W = (MAX_MEMBERS > 2) ? $clog2(MAX_MEMBERS) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_MEMBERS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	// ---- config registers ----
	logic [STRIP_BITS-1:0] max_dist_q;
	logic [TIME_BITS-1:0]  window_q;
	logic                  side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= STRIP_BITS'(1);
			window_q   <= TIME_BITS'(4);
			side_q     <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				stc_pkg::CFG_MAX_DIST: max_dist_q <= cfg_data[STRIP_BITS-1:0];
				stc_pkg::CFG_WINDOW:   window_q   <= cfg_data[TIME_BITS-1:0];
				stc_pkg::CFG_SIDE:     side_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---- control ----
	stc_pkg::state_t state_q, state_d;

	logic in_acc;
	logic commit_go;
	logic out_vld_q;
	logic [TIME_BITS-1:0] t_sel;

	// captured word
	logic                        cmd_q;
	logic [stc_pkg::ID_BITS-1:0] id_q;
	logic [STRIP_BITS-1:0]       strip_q;
	logic [TIME_BITS-1:0]        tsel_q;
	logic                        match_q;

	// cluster summary
	logic [CNT_W-1:0]            count_q, count_d;
	logic [stc_pkg::ID_BITS-1:0] cid_q, cid_d;
	logic [TIME_BITS-1:0]        ctime_q, ctime_d;

	// cell row
	stc_pkg::tok_ctl_t     tok   [MAX_MEMBERS+1];
	logic [STRIP_BITS-1:0] tok_s [MAX_MEMBERS+1];
	logic [TIME_BITS-1:0]  tok_t [MAX_MEMBERS+1];
	stc_pkg::wr_ctl_t      wr;
	logic [IDX_W-1:0]      wr_idx;

	logic is_start;
	logic full;
	logic store;
	logic full_rej;

	assign t_sel  = side_q ? hit.time_second : hit.time_first;
	assign in_acc = hit.valid && hit.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stc_pkg::ST_IDLE:
				if (in_acc) begin
					state_d = (hit.command == stc_pkg::CMD_START) ? stc_pkg::ST_COMMIT
						: stc_pkg::ST_SCAN;
				end
			stc_pkg::ST_SCAN:
				if (tok[MAX_MEMBERS].vld) begin
					state_d = stc_pkg::ST_COMMIT;
				end
			stc_pkg::ST_COMMIT:
				if (commit_go) begin
					state_d = stc_pkg::ST_IDLE;
				end
			default: state_d = stc_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		hit.ready = (state_q == stc_pkg::ST_IDLE);
		commit_go = (state_q == stc_pkg::ST_COMMIT) && (!out_vld_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= hit.command;
			id_q    <= hit.hit_id;
			strip_q <= hit.strip;
			tsel_q  <= t_sel;
		end
		if (state_q == stc_pkg::ST_SCAN && tok[MAX_MEMBERS].vld) begin
			match_q <= tok[MAX_MEMBERS].match;
		end
	end

	// probe enters cell 0 in the accept cycle of an offer
	assign tok[0].vld   = in_acc && (hit.command == stc_pkg::CMD_OFFER);
	assign tok[0].match = 1'b0;
	assign tok_s[0]     = hit.strip;
	assign tok_t[0]     = t_sel;

	for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_cell
		stc_cell #(
			.STRIP_BITS (STRIP_BITS),
			.TIME_BITS  (TIME_BITS),
			.IDX_W      (IDX_W),
			.CELL_IDX   (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.max_dist      (max_dist_q),
			.window        (window_q),
			.tok_in        (tok[i]),
			.tok_strip_in  (tok_s[i]),
			.tok_time_in   (tok_t[i]),
			.tok_out       (tok[i+1]),
			.tok_strip_out (tok_s[i+1]),
			.tok_time_out  (tok_t[i+1]),
			.wr            (wr),
			.wr_idx        (wr_idx),
			.wr_strip      (strip_q),
			.wr_time       (tsel_q)
		);
	end

	// ---- commit decision ----
	always_comb begin
		is_start = (cmd_q == stc_pkg::CMD_START);
		full     = (count_q == CNT_FULL);
		store    = is_start || (match_q && !full);
		full_rej = !is_start && match_q && full;

		wr.clear = commit_go && is_start;
		wr.en    = commit_go && store;
		wr_idx   = is_start ? '0 : count_q[IDX_W-1:0];

		count_d = count_q;
		cid_d   = cid_q;
		ctime_d = ctime_q;
		if (is_start) begin
			count_d = CNT_ONE;
			cid_d   = id_q;
			ctime_d = tsel_q;
		end else if (store) begin
			count_d = count_q + CNT_ONE;
			if (tsel_q < ctime_q) begin
				cid_d   = id_q;
				ctime_d = tsel_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cid_q   <= '0;
			ctime_q <= '0;
		end else if (commit_go) begin
			count_q <= count_d;
			cid_q   <= cid_d;
			ctime_q <= ctime_d;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit_go) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			result.accepted     <= store;
			result.full_reject  <= full_rej;
			result.member_count <= count_d;
			result.center_id    <= cid_d;
			result.center_time  <= ctime_d;
		end
	end

	assign result.valid = out_vld_q;

endmodule
